@@ src/dtb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared constants of the dominator tree builder: default sizes, command,
// status and register index codes.
// ----------------------------------------------------------------------------
package dtb_pkg;

  // default capacities
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 4096;

  // item command codes
  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

endpackage

@@ src/dominator_tree_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dominator_tree_builder
// Lengauer-Tarjan dominator tree over a loaded edge list. All per-vertex and
// per-edge state sits in synchronous single-read memories driven by one
// sequencer that reads, modifies and writes back one entry per step.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  ---------+-----------+---------------------------------------------------
//  in_*     | input     | cmd, edge_from, edge_to, query_node (tdata)
//  out_*    | output    | status, reachable, dfs_number, idom_node,
//           |           | idom_dfs, reached_count (tdata)
//  cfg_*    | input     | node_count (index 0), source_node (index 1)
//
// Clear and add items are answered from the idle state; a query item makes
// three chained memory reads. A compute item sets up all MAX_NODES table
// entries, then scans every stored edge for every reached vertex in both the
// walk and the predecessor scan, and runs path compression one step at a
// time; each memory has a single read port, so these reads follow one another.
// No clearing pass after reset: results count as absent until the first
// compute. A result waits in the output register while the next item is
// taken once that register is free or being emptied.

module dominator_tree_builder
  import dtb_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic        clk,
  input  logic        rst_n,
  // cmd[1:0], edge_from[11:2], edge_to[21:12], query_node[31:22]
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // status[1:0], reachable[2], dfs_number[12:3], idom_node[22:13],
  // idom_dfs[32:23], reached_count[43:33], zero fill[47:44]
  output logic [47:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_wdata
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int LW  = (CW > 11) ? CW : 11;
  localparam int SW  = 2 * NW + ECW;

  localparam logic [CW-1:0] UNV = CW'(MAX_NODES);

  typedef enum logic [35:0] {
    S_IDLE    = 36'b1 << 0,
    S_Q_VIS   = 36'b1 << 1,
    S_Q_IDOM  = 36'b1 << 2,
    S_Q_ORD   = 36'b1 << 3,
    S_INIT    = 36'b1 << 4,
    S_D_START = 36'b1 << 5,
    S_D_SCAN  = 36'b1 << 6,
    S_D_POP   = 36'b1 << 7,
    S_D_EDGE  = 36'b1 << 8,
    S_D_VIS   = 36'b1 << 9,
    S_L_INIT  = 36'b1 << 10,
    S_L_J     = 36'b1 << 11,
    S_L_U     = 36'b1 << 12,
    S_P_SCAN  = 36'b1 << 13,
    S_P_EDGE  = 36'b1 << 14,
    S_P_VIS   = 36'b1 << 15,
    S_P_LBL   = 36'b1 << 16,
    S_P_SEMI  = 36'b1 << 17,
    S_C_UP    = 36'b1 << 18,
    S_C_DOWN  = 36'b1 << 19,
    S_C_D1    = 36'b1 << 20,
    S_C_D2    = 36'b1 << 21,
    S_C_D3    = 36'b1 << 22,
    S_C_D4    = 36'b1 << 23,
    S_C_D5    = 36'b1 << 24,
    S_B_INS   = 36'b1 << 25,
    S_B_INS2  = 36'b1 << 26,
    S_B_PAR   = 36'b1 << 27,
    S_B_HEAD  = 36'b1 << 28,
    S_B_LOOP  = 36'b1 << 29,
    S_B_LBL   = 36'b1 << 30,
    S_B_IDOM  = 36'b1 << 31,
    S_B_NEXT  = 36'b1 << 32,
    S_F_RD    = 36'b1 << 33,
    S_F_CMP   = 36'b1 << 34,
    S_F_UPD   = 36'b1 << 35
  } state_t;

  // widen a vertex index to a 10-bit output field
  function automatic logic [9:0] fld10(input logic [NW-1:0] v);
    logic [LW-1:0] t;
    t = LW'(v);
    return t[9:0];
  endfunction

  // widen a count to the 11-bit output field
  function automatic logic [10:0] fld11(input logic [CW-1:0] v);
    logic [LW-1:0] t;
    t = LW'(v);
    return t[10:0];
  endfunction

  // input item fields
  logic [1:0] in_cmd;
  logic [9:0] in_from, in_to, in_q;
  logic       in_fire;
  assign in_cmd  = in_tdata[1:0];
  assign in_from = in_tdata[11:2];
  assign in_to   = in_tdata[21:12];
  assign in_q    = in_tdata[31:22];

  // control and working registers
  state_t          state_r, state_nxt;
  logic [10:0]     nc_r;
  logic [9:0]      src_cfg_r;
  logic [ECW-1:0]  edge_total_r, edge_total_nxt;
  logic [CW-1:0]   reached_r, reached_nxt;
  logic            computed_r, computed_nxt;
  logic [LW-1:0]   n_r, n_nxt, s_r, s_nxt;
  logic [CW-1:0]   sz_r, sz_nxt, depth_r, depth_nxt, m_r, m_nxt;
  logic [CW-1:0]   k_r, k_nxt, i_r, i_nxt;
  logic [NW-1:0]   top_u_r, top_u_nxt, top_n_r, top_n_nxt;
  logic [ECW-1:0]  top_c_r, top_c_nxt, ei_r, ei_nxt;
  logic [NW-1:0]   dst_r, dst_nxt, j_r, j_nxt, u_r, u_nxt;
  logic [NW-1:0]   semi_j_r, semi_j_nxt, x_r, x_nxt, z_r, z_nxt, v_r, v_nxt;
  logic [NW-1:0]   cx_r, cx_nxt, root_r, root_nxt;
  logic [NW-1:0]   lx_r, lx_nxt, lp_r, lp_nxt, sx_r, sx_nxt;
  logic [NW-1:0]   idfs_r, idfs_nxt, dnum_r, dnum_nxt;
  logic            ret_r, ret_nxt;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_reach_r;
  logic [9:0]  out_dfs_r, out_inode_r, out_idfs_r;
  logic [10:0] out_count_r;

  // result load
  logic        ld;
  logic [1:0]  ld_status;
  logic        ld_reach;
  logic [9:0]  ld_dfs, ld_inode, ld_idfs;
  logic [10:0] ld_count;

  // memory ports
  logic           e_we;
  logic [EW-1:0]  e_wa, e_ra;
  logic [NW-1:0]  e_wsrc, e_wdst, esrc_q, etgt_q;
  logic           vis_we;
  logic [NW-1:0]  vis_wa, vis_ra;
  logic [CW-1:0]  vis_wd, vis_q;
  logic           ord_we;
  logic [NW-1:0]  ord_wa, ord_wd, ord_ra, ord_q;
  logic           par_we;
  logic [NW-1:0]  par_wa, par_wd, par_ra, par_q;
  logic           semi_we;
  logic [NW-1:0]  semi_wa, semi_wd, semi_ra, semi_q;
  logic           link_we;
  logic [NW-1:0]  link_wa, link_wd, link_ra, link_q;
  logic           lbl_we;
  logic [NW-1:0]  lbl_wa, lbl_wd, lbl_ra, lbl_q;
  logic           idom_we;
  logic [NW-1:0]  idom_wa, idom_wd, idom_ra, idom_q;
  logic           head_we;
  logic [NW-1:0]  head_wa, head_ra;
  logic [CW-1:0]  head_wd, head_q;
  logic           next_we;
  logic [NW-1:0]  next_wa, next_ra;
  logic [CW-1:0]  next_wd, next_q;
  logic           stk_we;
  logic [NW-1:0]  stk_wa, stk_ra;
  logic [SW-1:0]  stk_wd, stk_q;

  // memories
  logic [NW-1:0] esrc_mem [MAX_EDGES];
  logic [NW-1:0] etgt_mem [MAX_EDGES];
  logic [CW-1:0] visit_mem [MAX_NODES];
  logic [NW-1:0] order_mem [MAX_NODES];
  logic [NW-1:0] parent_mem [MAX_NODES];
  logic [NW-1:0] semi_mem [MAX_NODES];
  logic [NW-1:0] link_mem [MAX_NODES];
  logic [NW-1:0] label_mem [MAX_NODES];
  logic [NW-1:0] idom_mem [MAX_NODES];
  logic [CW-1:0] head_mem [MAX_NODES];
  logic [CW-1:0] next_mem [MAX_NODES];
  logic [SW-1:0] stack_mem [MAX_NODES];

  // derived values
  logic [LW-1:0] nc_ext, live, from_ext, to_ext, q_ext;
  logic [LW-1:0] esrc_ext, etgt_ext, sz_ext;
  logic [CW-1:0] sz_m1, depth_m1, depth_m2, k_m1, m_m1;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_count_r, out_idfs_r, out_inode_r, out_dfs_r,
                       out_reach_r, out_status_r};

  // effective vertex count and widened fields
  always_comb begin
    nc_ext   = LW'(nc_r);
    if (nc_r == 11'd0) begin
      live = LW'(1);
    end else if (nc_ext > LW'(MAX_NODES)) begin
      live = LW'(MAX_NODES);
    end else begin
      live = nc_ext;
    end
    from_ext = LW'(in_from);
    to_ext   = LW'(in_to);
    q_ext    = LW'(in_q);
    esrc_ext = LW'(esrc_q);
    etgt_ext = LW'(etgt_q);
    sz_ext   = LW'(sz_r);
    sz_m1    = sz_r - CW'(1);
    depth_m1 = depth_r - CW'(1);
    depth_m2 = depth_r - CW'(2);
    k_m1     = k_r - CW'(1);
    m_m1     = m_r - CW'(1);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    edge_total_nxt = edge_total_r;
    reached_nxt    = reached_r;
    computed_nxt   = computed_r;
    n_nxt = n_r;       s_nxt = s_r;       sz_nxt = sz_r;
    depth_nxt = depth_r; m_nxt = m_r;     k_nxt = k_r;     i_nxt = i_r;
    top_u_nxt = top_u_r; top_n_nxt = top_n_r; top_c_nxt = top_c_r;
    ei_nxt = ei_r;     dst_nxt = dst_r;   j_nxt = j_r;     u_nxt = u_r;
    semi_j_nxt = semi_j_r; x_nxt = x_r;   z_nxt = z_r;     v_nxt = v_r;
    cx_nxt = cx_r;     root_nxt = root_r; lx_nxt = lx_r;   lp_nxt = lp_r;
    sx_nxt = sx_r;     idfs_nxt = idfs_r; dnum_nxt = dnum_r; ret_nxt = ret_r;

    ld = 1'b0;  ld_status = ST_OK;  ld_reach = 1'b0;
    ld_dfs = '0; ld_inode = '0; ld_idfs = '0;
    ld_count = fld11(reached_r);

    e_we = 1'b0;   e_wa = '0;   e_ra = '0;
    e_wsrc = from_ext[NW-1:0];  e_wdst = to_ext[NW-1:0];
    vis_we = 1'b0; vis_wa = '0; vis_wd = '0; vis_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
    semi_we = 1'b0; semi_wa = '0; semi_wd = '0; semi_ra = '0;
    link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = '0;
    lbl_we = 1'b0; lbl_wa = '0; lbl_wd = '0; lbl_ra = '0;
    idom_we = 1'b0; idom_wa = '0; idom_wd = '0; idom_ra = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_CLEAR: begin
              edge_total_nxt = '0;
              ld = 1'b1;
            end
            CMD_ADD: begin
              ld = 1'b1;
              if (from_ext >= live || to_ext >= live) begin
                ld_status = ST_RANGE;
              end else if (edge_total_r >= ECW'(MAX_EDGES)) begin
                ld_status = ST_FULL;
              end else begin
                e_we = 1'b1;
                e_wa = edge_total_r[EW-1:0];
                edge_total_nxt = edge_total_r + ECW'(1);
              end
            end
            CMD_COMPUTE: begin
              n_nxt        = live;
              s_nxt        = LW'(src_cfg_r);
              reached_nxt  = '0;
              computed_nxt = 1'b1;
              i_nxt        = '0;
              state_nxt    = S_INIT;
            end
            CMD_QUERY: begin
              if (q_ext >= live) begin
                ld = 1'b1;
                ld_status = ST_RANGE;
              end else begin
                vis_ra = q_ext[NW-1:0];
                state_nxt = S_Q_VIS;
              end
            end
            default: ;
          endcase
        end
      end

      // query: visit number, then dominator number, then its vertex
      S_Q_VIS: begin
        if (!computed_r || vis_q == UNV) begin
          ld = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          dnum_nxt = vis_q[NW-1:0];
          idom_ra = vis_q[NW-1:0];
          state_nxt = S_Q_IDOM;
        end
      end
      S_Q_IDOM: begin
        idfs_nxt = idom_q;
        ord_ra = idom_q;
        state_nxt = S_Q_ORD;
      end
      S_Q_ORD: begin
        ld = 1'b1;
        ld_reach = 1'b1;
        ld_dfs = fld10(dnum_r);
        ld_inode = fld10(ord_q);
        ld_idfs = fld10(idfs_r);
        state_nxt = S_IDLE;
      end

      // table set-up sweep
      S_INIT: begin
        vis_we = 1'b1;  vis_wa = i_r[NW-1:0];  vis_wd = UNV;
        semi_we = 1'b1; semi_wa = i_r[NW-1:0]; semi_wd = i_r[NW-1:0];
        link_we = 1'b1; link_wa = i_r[NW-1:0]; link_wd = i_r[NW-1:0];
        lbl_we = 1'b1;  lbl_wa = i_r[NW-1:0];  lbl_wd = i_r[NW-1:0];
        idom_we = 1'b1; idom_wa = i_r[NW-1:0]; idom_wd = '0;
        head_we = 1'b1; head_wa = i_r[NW-1:0]; head_wd = '0;
        i_nxt = i_r + CW'(1);
        if (i_r == CW'(MAX_NODES - 1)) begin
          if (s_r >= n_r) begin
            ld = 1'b1;
            ld_status = ST_RANGE;
            ld_count = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_D_START;
          end
        end
      end

      // depth-first walk, top frame held in registers
      S_D_START: begin
        vis_we = 1'b1; vis_wa = s_r[NW-1:0]; vis_wd = '0;
        ord_we = 1'b1; ord_wa = '0; ord_wd = s_r[NW-1:0];
        par_we = 1'b1; par_wa = '0; par_wd = '0;
        sz_nxt = CW'(1);
        depth_nxt = CW'(1);
        top_u_nxt = s_r[NW-1:0];
        top_c_nxt = '0;
        top_n_nxt = '0;
        state_nxt = S_D_SCAN;
      end
      S_D_SCAN: begin
        if (top_c_r == edge_total_r) begin
          if (depth_r == CW'(1)) begin
            state_nxt = S_L_INIT;
          end else begin
            depth_nxt = depth_m1;
            stk_ra = depth_m2[NW-1:0];
            state_nxt = S_D_POP;
          end
        end else begin
          e_ra = top_c_r[EW-1:0];
          state_nxt = S_D_EDGE;
        end
      end
      S_D_POP: begin
        top_u_nxt = stk_q[NW-1:0];
        top_c_nxt = stk_q[NW+ECW-1:NW];
        top_n_nxt = stk_q[SW-1:NW+ECW];
        state_nxt = S_D_SCAN;
      end
      S_D_EDGE: begin
        top_c_nxt = top_c_r + ECW'(1);
        if (esrc_q == top_u_r && esrc_ext < n_r && etgt_ext < n_r) begin
          vis_ra = etgt_q;
          dst_nxt = etgt_q;
          state_nxt = S_D_VIS;
        end else begin
          state_nxt = S_D_SCAN;
        end
      end
      S_D_VIS: begin
        if (vis_q == UNV && sz_ext < n_r) begin
          vis_we = 1'b1; vis_wa = dst_r; vis_wd = sz_r;
          ord_we = 1'b1; ord_wa = sz_r[NW-1:0]; ord_wd = dst_r;
          par_we = 1'b1; par_wa = sz_r[NW-1:0]; par_wd = top_n_r;
          stk_we = 1'b1; stk_wa = depth_m1[NW-1:0];
          stk_wd = {top_n_r, top_c_r, top_u_r};
          top_u_nxt = dst_r;
          top_c_nxt = '0;
          top_n_nxt = sz_r[NW-1:0];
          sz_nxt = sz_r + CW'(1);
          depth_nxt = depth_r + CW'(1);
        end
        state_nxt = S_D_SCAN;
      end

      // semidominator pass, highest visit number first
      S_L_INIT: begin
        j_nxt = sz_m1[NW-1:0];
        i_nxt = CW'(1);
        state_nxt = (sz_r == CW'(1)) ? S_F_RD : S_L_J;
      end
      S_L_J: begin
        ord_ra = j_r;
        semi_j_nxt = j_r;
        state_nxt = S_L_U;
      end
      S_L_U: begin
        u_nxt = ord_q;
        ei_nxt = '0;
        state_nxt = S_P_SCAN;
      end
      S_P_SCAN: begin
        if (ei_r == edge_total_r) begin
          state_nxt = S_B_INS;
        end else begin
          e_ra = ei_r[EW-1:0];
          state_nxt = S_P_EDGE;
        end
      end
      S_P_EDGE: begin
        ei_nxt = ei_r + ECW'(1);
        if (etgt_q == u_r && esrc_ext < n_r && etgt_ext < n_r) begin
          vis_ra = esrc_q;
          state_nxt = S_P_VIS;
        end else begin
          state_nxt = S_P_SCAN;
        end
      end
      S_P_VIS: begin
        if (vis_q == UNV) begin
          state_nxt = S_P_SCAN;
        end else begin
          v_nxt = vis_q[NW-1:0];
          cx_nxt = vis_q[NW-1:0];
          link_ra = vis_q[NW-1:0];
          k_nxt = '0;
          ret_nxt = 1'b0;
          state_nxt = S_C_UP;
        end
      end
      S_P_LBL: begin
        semi_ra = lbl_q;
        state_nxt = S_P_SEMI;
      end
      S_P_SEMI: begin
        if (semi_q < semi_j_r) begin
          semi_j_nxt = semi_q;
        end
        state_nxt = S_P_SCAN;
      end

      // path compression: climb to the root, then unwind
      S_C_UP: begin
        if (link_q == cx_r) begin
          root_nxt = cx_r;
          state_nxt = S_C_DOWN;
        end else begin
          stk_we = 1'b1;
          stk_wa = k_r[NW-1:0];
          stk_wd = SW'(cx_r);
          k_nxt = k_r + CW'(1);
          cx_nxt = link_q;
          link_ra = link_q;
        end
      end
      S_C_DOWN: begin
        if (k_r == '0) begin
          lbl_ra = ret_r ? z_r : v_r;
          state_nxt = ret_r ? S_B_LBL : S_P_LBL;
        end else begin
          k_nxt = k_m1;
          stk_ra = k_m1[NW-1:0];
          state_nxt = S_C_D1;
        end
      end
      S_C_D1: begin
        cx_nxt = stk_q[NW-1:0];
        link_ra = stk_q[NW-1:0];
        lbl_ra = stk_q[NW-1:0];
        state_nxt = S_C_D2;
      end
      S_C_D2: begin
        lx_nxt = lbl_q;
        lbl_ra = link_q;
        state_nxt = S_C_D3;
      end
      S_C_D3: begin
        lp_nxt = lbl_q;
        semi_ra = lx_r;
        state_nxt = S_C_D4;
      end
      S_C_D4: begin
        sx_nxt = semi_q;
        semi_ra = lp_r;
        state_nxt = S_C_D5;
      end
      S_C_D5: begin
        lbl_we = 1'b1;
        lbl_wa = cx_r;
        lbl_wd = (sx_r > semi_q) ? lp_r : lx_r;
        link_we = 1'b1;
        link_wa = cx_r;
        link_wd = root_r;
        state_nxt = S_C_DOWN;
      end

      // bucket insert, link to parent, drain parent bucket
      S_B_INS: begin
        semi_we = 1'b1; semi_wa = j_r; semi_wd = semi_j_r;
        head_ra = semi_j_r;
        state_nxt = S_B_INS2;
      end
      S_B_INS2: begin
        next_we = 1'b1; next_wa = j_r; next_wd = head_q;
        head_we = 1'b1; head_wa = semi_j_r; head_wd = CW'(j_r) + CW'(1);
        par_ra = j_r;
        state_nxt = S_B_PAR;
      end
      S_B_PAR: begin
        x_nxt = par_q;
        link_we = 1'b1; link_wa = j_r; link_wd = par_q;
        head_ra = par_q;
        state_nxt = S_B_HEAD;
      end
      S_B_HEAD: begin
        m_nxt = head_q;
        state_nxt = S_B_LOOP;
      end
      S_B_LOOP: begin
        if (m_r == '0) begin
          head_we = 1'b1; head_wa = x_r; head_wd = '0;
          if (j_r == NW'(1)) begin
            state_nxt = S_F_RD;
          end else begin
            j_nxt = j_r - NW'(1);
            state_nxt = S_L_J;
          end
        end else begin
          z_nxt = m_m1[NW-1:0];
          cx_nxt = m_m1[NW-1:0];
          link_ra = m_m1[NW-1:0];
          k_nxt = '0;
          ret_nxt = 1'b1;
          state_nxt = S_C_UP;
        end
      end
      S_B_LBL: begin
        lx_nxt = lbl_q;
        semi_ra = lbl_q;
        state_nxt = S_B_IDOM;
      end
      S_B_IDOM: begin
        idom_we = 1'b1;
        idom_wa = z_r;
        idom_wd = (semi_q < x_r) ? lx_r : x_r;
        next_ra = z_r;
        state_nxt = S_B_NEXT;
      end
      S_B_NEXT: begin
        m_nxt = next_q;
        state_nxt = S_B_LOOP;
      end

      // final fix-up in visit order
      S_F_RD: begin
        if (i_r == sz_r) begin
          reached_nxt = sz_r;
          ld = 1'b1;
          ld_count = fld11(sz_r);
          state_nxt = S_IDLE;
        end else begin
          semi_ra = i_r[NW-1:0];
          idom_ra = i_r[NW-1:0];
          state_nxt = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (semi_q != idom_q) begin
          idom_ra = idom_q;
          state_nxt = S_F_UPD;
        end else begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_F_RD;
        end
      end
      S_F_UPD: begin
        idom_we = 1'b1;
        idom_wa = i_r[NW-1:0];
        idom_wd = idom_q;
        i_nxt = i_r + CW'(1);
        state_nxt = S_F_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edge_total_r <= '0;
      reached_r    <= '0;
      computed_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      nc_r         <= 11'd1;
      src_cfg_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      edge_total_r <= edge_total_nxt;
      reached_r    <= reached_nxt;
      computed_r   <= computed_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_NODE_COUNT:  nc_r <= cfg_wdata;
          REG_SOURCE_NODE: src_cfg_r <= cfg_wdata[9:0];
          default: ;
        endcase
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    n_r <= n_nxt;       s_r <= s_nxt;       sz_r <= sz_nxt;
    depth_r <= depth_nxt; m_r <= m_nxt;     k_r <= k_nxt;     i_r <= i_nxt;
    top_u_r <= top_u_nxt; top_n_r <= top_n_nxt; top_c_r <= top_c_nxt;
    ei_r <= ei_nxt;     dst_r <= dst_nxt;   j_r <= j_nxt;     u_r <= u_nxt;
    semi_j_r <= semi_j_nxt; x_r <= x_nxt;   z_r <= z_nxt;     v_r <= v_nxt;
    cx_r <= cx_nxt;     root_r <= root_nxt; lx_r <= lx_nxt;   lp_r <= lp_nxt;
    sx_r <= sx_nxt;     idfs_r <= idfs_nxt; dnum_r <= dnum_nxt; ret_r <= ret_nxt;
    if (ld) begin
      out_status_r <= ld_status;
      out_reach_r  <= ld_reach;
      out_dfs_r    <= ld_dfs;
      out_inode_r  <= ld_inode;
      out_idfs_r   <= ld_idfs;
      out_count_r  <= ld_count;
    end
  end

  // edge store
  always_ff @(posedge clk) begin
    if (e_we) begin
      esrc_mem[e_wa] <= e_wsrc;
      etgt_mem[e_wa] <= e_wdst;
    end
    esrc_q <= esrc_mem[e_ra];
    etgt_q <= etgt_mem[e_ra];
  end

  // per-vertex tables
  always_ff @(posedge clk) begin
    if (vis_we) visit_mem[vis_wa] <= vis_wd;
    vis_q <= visit_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (ord_we) order_mem[ord_wa] <= ord_wd;
    ord_q <= order_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) parent_mem[par_wa] <= par_wd;
    par_q <= parent_mem[par_ra];
  end

  always_ff @(posedge clk) begin
    if (semi_we) semi_mem[semi_wa] <= semi_wd;
    semi_q <= semi_mem[semi_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (lbl_we) label_mem[lbl_wa] <= lbl_wd;
    lbl_q <= label_mem[lbl_ra];
  end

  always_ff @(posedge clk) begin
    if (idom_we) idom_mem[idom_wa] <= idom_wd;
    idom_q <= idom_mem[idom_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_q <= next_mem[next_ra];
  end

  // walk stack, shared by the search and by path compression
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_q <= stack_mem[stk_ra];
  end

  // checks
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= ECW'(MAX_EDGES))
    else $error("edge count beyond store size");

  a_walk_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_SCAN) |-> (sz_ext <= n_r && depth_r <= sz_r))
    else $error("walk depth or visit count out of bounds");

  a_quick_items: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cmd == CMD_CLEAR || in_cmd == CMD_ADD)) |=> out_valid_r)
    else $error("clear or add item gave no result");

  a_compress_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C_UP) |-> (k_r < CW'(MAX_NODES)))
    else $error("compression path too long");

endmodule

@@ verif/dominator_tree_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dominator_tree_checker
// Watches the item, result and register ports of the dominator tree builder.
// It keeps its own edge list and dominator tables, predicts one result per
// accepted item, and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module dominator_tree_checker
  import dtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // cmd[1:0], edge_from[11:2], edge_to[21:12], query_node[31:22]
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // status[1:0], reachable[2], dfs_number[12:3], idom_node[22:13],
  // idom_dfs[32:23], reached_count[43:33]
  input  logic [47:0] out_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_wdata,
  output int          error_count,
  output int          pending
);

  localparam int NODES = DEF_MAX_NODES;
  localparam int EDGES = DEF_MAX_EDGES;

  typedef struct packed {
    logic [10:0] reached_count;
    logic [9:0]  idom_dfs;
    logic [9:0]  idom_node;
    logic [9:0]  dfs_number;
    logic        reachable;
    logic [1:0]  status;
  } dom_result_t;

  dom_result_t result_q[$];

  // shadow of the block state
  int unsigned edge_src[EDGES], edge_dst[EDGES], edge_cnt;
  int unsigned visit[NODES], order_v[NODES], parent_n[NODES];
  int unsigned semi[NODES], flink[NODES], best[NODES], idom_n[NODES];
  int unsigned bhead[NODES], bnext[NODES], walk_v[NODES], walk_c[NODES];
  int unsigned succ_off[NODES+1], succ_l[EDGES], pred_off[NODES+1], pred_l[EDGES];
  int unsigned fill_pos[NODES];
  int unsigned reached, node_reg, source_reg;

  function automatic int unsigned live_nodes();
    if (node_reg == 0) return 1;
    if (node_reg > NODES) return NODES;
    return node_reg;
  endfunction

  // stable adjacency lists in load order, forward or reversed
  function void build_adj(int unsigned n, bit rev);
    int unsigned i, k, v;
    for (i = 0; i <= n; i++) begin
      if (rev) pred_off[i] = 0; else succ_off[i] = 0;
    end
    for (i = 0; i < edge_cnt; i++) begin
      k = rev ? edge_dst[i] : edge_src[i];
      v = rev ? edge_src[i] : edge_dst[i];
      if (k < n && v < n) begin
        if (rev) pred_off[k+1]++; else succ_off[k+1]++;
      end
    end
    for (i = 0; i < n; i++) begin
      if (rev) begin
        pred_off[i+1] += pred_off[i];
        fill_pos[i] = pred_off[i];
      end else begin
        succ_off[i+1] += succ_off[i];
        fill_pos[i] = succ_off[i];
      end
    end
    for (i = 0; i < edge_cnt; i++) begin
      k = rev ? edge_dst[i] : edge_src[i];
      v = rev ? edge_src[i] : edge_dst[i];
      if (k < n && v < n) begin
        if (rev) pred_l[fill_pos[k]] = v; else succ_l[fill_pos[k]] = v;
        fill_pos[k]++;
      end
    end
  endfunction

  // forest root lookup with path compression and label update
  function void compress(int unsigned v);
    int unsigned k, x, root, p;
    k = 0;
    x = v;
    while (flink[x] != x && k < NODES) begin
      walk_v[k] = x;
      k++;
      x = flink[x];
    end
    root = x;
    while (k > 0) begin
      k--;
      x = walk_v[k];
      p = flink[x];
      if (semi[best[x]] > semi[best[p]]) best[x] = best[p];
      flink[x] = root;
    end
  endfunction

  function logic [1:0] build_dominators();
    int unsigned n, s, i, sz, depth, u, c, v, e, tv, x, m, z;
    int j;
    n = live_nodes();
    s = source_reg;
    for (i = 0; i < NODES; i++) begin
      visit[i] = NODES;
      semi[i] = i;
      flink[i] = i;
      best[i] = i;
      idom_n[i] = 0;
      bhead[i] = 0;
    end
    reached = 0;
    if (s >= n) return ST_RANGE;
    build_adj(n, 1'b0);
    build_adj(n, 1'b1);

    // depth-first numbering with an explicit stack
    visit[s] = 0;
    order_v[0] = s;
    parent_n[0] = 0;
    sz = 1;
    walk_v[0] = s;
    walk_c[0] = succ_off[s];
    depth = 1;
    while (depth > 0) begin
      u = walk_v[depth-1];
      c = walk_c[depth-1];
      if (c < succ_off[u+1]) begin
        v = succ_l[c];
        walk_c[depth-1] = c + 1;
        if (visit[v] == NODES && sz < n && depth < NODES) begin
          visit[v] = sz;
          order_v[sz] = v;
          parent_n[sz] = visit[u];
          sz++;
          walk_v[depth] = v;
          walk_c[depth] = succ_off[v];
          depth++;
        end
      end else begin
        depth--;
      end
    end

    // semidominators and bucket processing in reverse visit order
    for (j = sz - 1; j > 0; j--) begin
      u = order_v[j];
      for (e = pred_off[u]; e < pred_off[u+1]; e++) begin
        tv = pred_l[e];
        if (visit[tv] != NODES) begin
          v = visit[tv];
          compress(v);
          if (semi[best[v]] < semi[j]) semi[j] = semi[best[v]];
        end
      end
      bnext[j] = bhead[semi[j]];
      bhead[semi[j]] = j + 1;
      x = parent_n[j];
      flink[j] = x;
      m = bhead[x];
      while (m != 0) begin
        z = m - 1;
        compress(z);
        idom_n[z] = (semi[best[z]] < x) ? best[z] : x;
        m = bnext[z];
      end
      bhead[x] = 0;
    end
    idom_n[0] = 0;
    for (i = 1; i < sz; i++)
      if (semi[i] != idom_n[i]) idom_n[i] = idom_n[idom_n[i]];
    reached = sz;
    return ST_OK;
  endfunction

  function dom_result_t predict_item(logic [31:0] item);
    dom_result_t r;
    logic [1:0] cmd;
    int unsigned from, to, q, n, idfs;
    cmd = item[1:0];
    from = item[11:2];
    to = item[21:12];
    q = item[31:22];
    n = live_nodes();
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        edge_cnt = 0;
      end
      CMD_ADD: begin
        if (from >= n || to >= n) r.status = ST_RANGE;
        else if (edge_cnt >= EDGES) r.status = ST_FULL;
        else begin
          edge_src[edge_cnt] = from;
          edge_dst[edge_cnt] = to;
          edge_cnt++;
        end
      end
      CMD_COMPUTE: begin
        r.status = build_dominators();
      end
      default: begin
        if (q >= n) r.status = ST_RANGE;
        else if (visit[q] != NODES) begin
          idfs = idom_n[visit[q] % NODES] % NODES;
          r.reachable = 1'b1;
          r.dfs_number = visit[q];
          r.idom_dfs = idfs;
          r.idom_node = order_v[idfs];
        end
      end
    endcase
    r.reached_count = reached;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NODES; i++) begin
      visit[i] = NODES;
      order_v[i] = 0;
      idom_n[i] = 0;
    end
    edge_cnt = 0;
    reached = 0;
    node_reg = 1;
    source_reg = 0;
    error_count = 0;
  end

  assign pending = result_q.size();

  // results are checked before new items are predicted in the same cycle
  always @(posedge clk) begin
    dom_result_t exp_r, got_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_r = out_tdata[43:0];
        if (result_q.size() == 0) begin
          $error("unexpected result item %h", out_tdata);
          error_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (got_r.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
            error_count++;
          end
          if (got_r.reachable !== exp_r.reachable) begin
            $error("reachable: expected %0d, got %0d", exp_r.reachable, got_r.reachable);
            error_count++;
          end
          if (got_r.dfs_number !== exp_r.dfs_number) begin
            $error("dfs_number: expected %0d, got %0d", exp_r.dfs_number, got_r.dfs_number);
            error_count++;
          end
          if (got_r.idom_node !== exp_r.idom_node) begin
            $error("idom_node: expected %0d, got %0d", exp_r.idom_node, got_r.idom_node);
            error_count++;
          end
          if (got_r.idom_dfs !== exp_r.idom_dfs) begin
            $error("idom_dfs: expected %0d, got %0d", exp_r.idom_dfs, got_r.idom_dfs);
            error_count++;
          end
          if (got_r.reached_count !== exp_r.reached_count) begin
            $error("reached_count: expected %0d, got %0d",
                   exp_r.reached_count, got_r.reached_count);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) result_q.push_back(predict_item(in_tdata));
      if (cfg_we) begin
        if (cfg_addr == REG_NODE_COUNT) node_reg = cfg_wdata;
        else source_reg = cfg_wdata[9:0];
      end
    end
  end

endmodule

@@ verif/dominator_tree_builder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dominator_tree_builder_tb
// Drives edge loads, dominator computes and vertex queries into the block
// under random idling on both channels, including a full edge store and a
// long result stall; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module dominator_tree_builder_tb;
  import dtb_pkg::*;

  localparam int STALL_LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic [31:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_we;
  logic        cfg_addr;
  logic [10:0] cfg_wdata;
  int          error_count;
  int          pending;
  int          send_idle;
  int          recv_idle;
  bit          long_hold;

  dominator_tree_builder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  dominator_tree_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .error_count(error_count), .pending(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (long_hold) begin
      out_tready <= 1'b0;
      repeat (400) @(posedge clk);
      long_hold = 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [9:0] from, logic [9:0] to,
                           logic [9:0] q);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {q, to, from, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  // let all results come back, then the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [9:0] pick_node(int unsigned n);
    if ($urandom_range(9) == 0) return $urandom_range(1023);
    return $urandom_range(n - 1);
  endfunction

  initial begin
    int unsigned n;
    int ne;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_NODE_COUNT;
    cfg_wdata = '0;
    long_hold = 1'b0;
    send_idle = 17;
    recv_idle = 85;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single vertex, nothing computed yet
    send_item(CMD_QUERY, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 1023);
    send_item(CMD_ADD, 0, 0, 0);
    send_item(CMD_ADD, 1, 0, 0);
    send_item(CMD_COMPUTE, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0);
    drain();

    // zero vertex count, source out of range
    write_reg(REG_NODE_COUNT, 11'd0);
    write_reg(REG_SOURCE_NODE, 11'd1023);
    send_item(CMD_COMPUTE, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0);
    drain();

    // oversized count, extreme vertices
    write_reg(REG_NODE_COUNT, 11'd2047);
    send_item(CMD_CLEAR, 0, 0, 0);
    send_item(CMD_ADD, 1023, 0, 0);
    send_item(CMD_ADD, 0, 512, 0);
    send_item(CMD_ADD, 1023, 512, 0);
    send_item(CMD_ADD, 512, 1023, 0);
    send_item(CMD_COMPUTE, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 1023);
    send_item(CMD_QUERY, 0, 0, 512);
    send_item(CMD_QUERY, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 1);
    drain();

    // stale edge beyond a reduced count
    write_reg(REG_NODE_COUNT, 11'd8);
    write_reg(REG_SOURCE_NODE, 11'd0);
    send_item(CMD_CLEAR, 0, 0, 0);
    send_item(CMD_ADD, 0, 3, 0);
    send_item(CMD_ADD, 3, 6, 0);
    send_item(CMD_ADD, 6, 1, 0);
    drain();
    write_reg(REG_NODE_COUNT, 11'd4);
    send_item(CMD_COMPUTE, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 3);
    send_item(CMD_QUERY, 0, 0, 1);
    drain();

    // fill the edge store, then overflow it
    write_reg(REG_NODE_COUNT, 11'd8);
    send_idle = 0;
    recv_idle = 0;
    send_item(CMD_CLEAR, 0, 0, 0);
    for (int i = 0; i < DEF_MAX_EDGES; i++)
      send_item(CMD_ADD, $urandom_range(7), $urandom_range(7), 0);
    send_item(CMD_ADD, 2, 5, 0);
    send_item(CMD_ADD, 9, 0, 0);
    send_item(CMD_COMPUTE, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_item(CMD_QUERY, 0, 0, i);
    send_item(CMD_CLEAR, 0, 0, 0);
    drain();

    // random graphs: load, compute, query
    for (int ph = 0; ph < 26; ph++) begin
      if (ph < 9) begin
        send_idle = 17;
        recv_idle = 85;
      end else if (ph < 18) begin
        send_idle = 85;
        recv_idle = 17;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      n = ($urandom_range(7) == 0) ? 1024 : $urandom_range(2, 20);
      write_reg(REG_NODE_COUNT, (n == 1024 && $urandom_range(1)) ? 11'd2047 : n);
      write_reg(REG_SOURCE_NODE, ($urandom_range(7) == 0) ? $urandom_range(1023)
                                                        : $urandom_range(n - 1));
      send_item(CMD_CLEAR, 0, 0, 0);
      ne = (n == 1024) ? 30 : $urandom_range(n, 2 * n);
      for (int i = 0; i < ne; i++)
        send_item(CMD_ADD, pick_node(n), pick_node(n), 0);
      send_item(CMD_COMPUTE, 0, 0, 0);
      if (ph == 20) long_hold = 1'b1;
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(15) == 0)
          send_item($urandom_range(2), pick_node(n), pick_node(n), 0);
        else
          send_item(CMD_QUERY, $urandom_range(1023), $urandom_range(1023), pick_node(n));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
